@@ src/windowed_range_average_assert.svh @@
// assertion macros for the windowed range averager
// expects clk and rst in the scope of use; no other dependencies
`ifndef WINDOWED_RANGE_AVERAGE_ASSERT_SVH
`define WINDOWED_RANGE_AVERAGE_ASSERT_SVH

// condition holds at every edge out of reset
`define WRA_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("windowed_range_average: invariant violated");

// same-cycle implication
`define WRA_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("windowed_range_average: implication violated");

// next-cycle implication
`define WRA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("windowed_range_average: next-cycle check violated");

`endif

@@ src/wra_pkg.sv @@
// shared types and constants for the windowed range averager
// used by wra_ctrl, wra_datapath and windowed_range_average; no dependencies
package wra_pkg;

  localparam int MAX_WINDOW_DEFAULT = 64;
  localparam int SAMPLE_BITS        = 16;
  localparam int FRACTION_BITS      = 8;
  localparam int AVERAGE_W          = 24;
  localparam int WINDOW_LEN_W       = 7;
  localparam int RETRY_LIMIT_W      = 8;
  localparam int CFG_DATA_W         = 8;

  localparam logic [WINDOW_LEN_W-1:0]  WINDOW_LEN_RESET  = 7'd16;
  localparam logic [RETRY_LIMIT_W-1:0] RETRY_LIMIT_RESET = 8'd3;

  typedef enum logic {
    CMD_SAMPLE  = 1'b0,
    CMD_FAILURE = 1'b1
  } command_t;

  typedef enum logic {
    CFG_WINDOW_LEN  = 1'b0,
    CFG_RETRY_LIMIT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    command_t                command;
    logic [SAMPLE_BITS-1:0]  sample;
  } item_t;

  typedef struct packed {
    logic [AVERAGE_W-1:0] average;
    logic                 reading;
    logic                 restarted;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic update;
    logic div_step;
    logic emit;
  } wra_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic fail;
    logic div_last;
  } wra_status_t;

endpackage

@@ src/wra_ctrl.sv @@
// sequencing state machine for the windowed range averager
// depends on wra_pkg for the command and status structs
module wra_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 result_stall,
  input  wra_pkg::wra_status_t status,
  output wra_pkg::wra_ctrl_t   ctrl,
  output logic                 item_stall,
  output logic                 result_valid
);
  import wra_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t state;

  // nothing is taken while reset is held
  assign item_stall = rst || (state != ST_IDLE);

  always_comb begin
    ctrl.accept   = item_valid && !item_stall;
    ctrl.update   = (state == ST_UPDATE);
    ctrl.div_step = (state == ST_DIVIDE);
    ctrl.emit     = (state == ST_FINISH) && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctrl.accept) begin
            state <= ST_READ;
          end
        end
        // ring read in flight
        ST_READ: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          state <= status.fail ? ST_FINISH : ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (status.div_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (ctrl.emit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (ctrl.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/wra_datapath.sv @@
// sample ring, running sum, failure counter and bit-serial divider
// depends on wra_pkg; driven by wra_ctrl through wra_ctrl_t
module wra_datapath #(
  parameter int MAX_WINDOW = wra_pkg::MAX_WINDOW_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  wra_pkg::item_t                  item,
  input  logic                            cfg_we,
  input  wra_pkg::cfg_index_t             cfg_index,
  input  logic [wra_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wra_pkg::wra_ctrl_t              ctrl,
  output wra_pkg::wra_status_t            status,
  output wra_pkg::result_t                result
);
  import wra_pkg::*;

  localparam int PW    = $clog2(MAX_WINDOW);
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int LW    = (CW > WINDOW_LEN_W) ? CW : WINDOW_LEN_W;
  localparam int SUM_W = SAMPLE_BITS + PW;
  localparam int DW    = SUM_W + FRACTION_BITS;
  localparam int IW    = $clog2(DW);

  // configuration
  logic [WINDOW_LEN_W-1:0]  window_len;
  logic [RETRY_LIMIT_W-1:0] retry_limit;

  // averaging state
  logic [SAMPLE_BITS-1:0]   ring [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0]   rd_data;
  logic [SUM_W-1:0]         running_sum;
  logic [PW-1:0]            write_position;
  logic                     ring_filled;
  logic [RETRY_LIMIT_W-1:0] failure_count;
  logic                     reading_flag;
  logic [AVERAGE_W-1:0]     held_average;
  logic                     restarted;

  // captured word
  command_t                 item_cmd;
  logic [SAMPLE_BITS-1:0]   item_sample;
  logic [PW-1:0]            item_pos;

  // divider
  logic [CW-1:0]            rem;
  logic [DW-1:0]            quo;
  logic [CW-1:0]            divisor;
  logic [IW-1:0]            div_idx;

  logic [LW-1:0]            wl_ext;
  logic [CW-1:0]            len;
  logic [PW-1:0]            pos_clamp;
  logic [CW-1:0]            pos_inc;
  logic                     wrap;
  logic [SUM_W-1:0]         sum_next;
  logic [CW-1:0]            count_next;
  logic [RETRY_LIMIT_W:0]   fail_next;
  logic [CW:0]              trial;
  logic                     ge;
  logic [CW-1:0]            rem_next;
  logic [DW-1:0]            quo_next;

  always_comb begin
    // window length clamped to 1..MAX_WINDOW
    wl_ext = LW'(window_len);
    if (wl_ext == '0) begin
      len = CW'(1);
    end else if (wl_ext > LW'(MAX_WINDOW)) begin
      len = CW'(MAX_WINDOW);
    end else begin
      len = CW'(wl_ext);
    end

    pos_clamp = (CW'(write_position) >= len) ? '0 : write_position;

    pos_inc    = CW'(item_pos) + CW'(1);
    wrap       = (pos_inc >= len);
    sum_next   = running_sum - (ring_filled ? SUM_W'(rd_data) : '0) + SUM_W'(item_sample);
    // never zero: a wrap sets the filled flag, otherwise at least one sample
    count_next = (wrap || ring_filled) ? len : pos_inc;

    fail_next = {1'b0, failure_count} + 1'b1;

    // restoring division, one quotient bit a cycle
    trial    = {rem, quo[DW-1]};
    ge       = (trial >= {1'b0, divisor});
    rem_next = ge ? CW'(trial - {1'b0, divisor}) : CW'(trial);
    quo_next = {quo[DW-2:0], ge};
  end

  assign status.fail     = (item_cmd == CMD_FAILURE);
  assign status.div_last = (div_idx == IW'(DW - 1));

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (ctrl.update && (item_cmd == CMD_SAMPLE)) begin
      ring[item_pos] <= item_sample;
    end
    rd_data <= ring[item_pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len     <= WINDOW_LEN_RESET;
      retry_limit    <= RETRY_LIMIT_RESET;
      running_sum    <= '0;
      write_position <= '0;
      ring_filled    <= 1'b0;
      failure_count  <= '0;
      reading_flag   <= 1'b0;
      held_average   <= '0;
      restarted      <= 1'b0;
      div_idx        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_LEN: begin
            window_len     <= cfg_data[WINDOW_LEN_W-1:0];
            running_sum    <= '0;
            write_position <= '0;
            ring_filled    <= 1'b0;
          end
          CFG_RETRY_LIMIT: begin
            retry_limit <= cfg_data[RETRY_LIMIT_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (ctrl.accept) begin
        restarted <= 1'b0;
      end

      if (ctrl.update) begin
        if (item_cmd == CMD_SAMPLE) begin
          running_sum    <= sum_next;
          write_position <= wrap ? '0 : PW'(pos_inc);
          if (wrap) begin
            ring_filled <= 1'b1;
          end
          failure_count <= '0;
          reading_flag  <= 1'b1;
          rem           <= '0;
          quo           <= DW'(sum_next) << FRACTION_BITS;
          divisor       <= count_next;
          div_idx       <= '0;
        end else if (fail_next > {1'b0, retry_limit}) begin
          running_sum    <= '0;
          write_position <= '0;
          ring_filled    <= 1'b0;
          failure_count  <= '0;
          reading_flag   <= 1'b0;
          restarted      <= 1'b1;
        end else begin
          failure_count <= fail_next[RETRY_LIMIT_W-1:0];
        end
      end

      if (ctrl.div_step) begin
        rem     <= rem_next;
        quo     <= quo_next;
        div_idx <= div_idx + 1'b1;
        if (status.div_last) begin
          held_average <= quo_next[AVERAGE_W-1:0];
        end
      end
    end
  end

  // captured word and output register
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      item_cmd    <= item.command;
      item_sample <= item.sample;
      item_pos    <= pos_clamp;
    end
    if (ctrl.emit) begin
      result.average   <= held_average;
      result.reading   <= reading_flag;
      result.restarted <= restarted;
    end
  end

endmodule

@@ src/windowed_range_average.sv @@
// windowed range averager: a sample word passes idle, ring read, update, divide and finish,
// with the divider producing DW = sample bits + clog2(MAX_WINDOW) + fraction bits quotient bits
// in the bit-serial divider, one quotient bit per cycle; a failure word skips the divide step
// one word in flight; the next word is taken once the result sits in the output register
// synchronous active-high reset restores defaults, clears averaging state, stalls inputs
// ring entries are left as they are after reset; no clearing pass
`include "windowed_range_average_assert.svh"

module windowed_range_average #(
  parameter int MAX_WINDOW = wra_pkg::MAX_WINDOW_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // input word channel
  input  logic                            item_valid,
  output logic                            item_stall,
  input  wra_pkg::item_t                  item,
  // result word channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output wra_pkg::result_t                result,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  wra_pkg::cfg_index_t             cfg_index,
  input  logic [wra_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wra_pkg::*;

  wra_ctrl_t   ctrl;
  wra_status_t status;
  logic        cfg_we;

  // register writes are taken only when no word is being worked on or offered,
  // so a write never lands on the same edge as an accepted word
  assign cfg_ready = !item_stall && !item_valid;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer: idle, ring read, update, divide, hand off to output register
  wra_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .result_stall (result_stall),
    .status       (status),
    .ctrl         (ctrl),
    .item_stall   (item_stall),
    .result_valid (result_valid)
  );

  // ring memory, running sum, failure tracking and divider
  wra_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .status    (status),
    .result    (result)
  );

  // a word that was just taken keeps the input stalled in the next cycle
  `WRA_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)
  // at most one command from the sequencer per cycle
  `WRA_ASSERT_HOLDS(a_single_command, $onehot0({ctrl.accept, ctrl.update, ctrl.div_step, ctrl.emit}))
  // a hand-off always shows up on the result channel
  `WRA_ASSERT_NEXT(a_emit_gives_valid, ctrl.emit, result_valid)
  // a restart never reports an online reading
  `WRA_ASSERT_IMPLIES(a_restart_not_reading, result_valid, !(result.restarted && result.reading))

endmodule
